### rtl/core/swle_pkg.sv
`default_nettype none

package swle_pkg;

  // Link modes
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2,
    MODE_ECHO = 2'd3
  } mode_t;

  // Input event kinds
  typedef enum logic [1:0] {
    OP_SEND_REQ = 2'd0,
    OP_RECV_REQ = 2'd1,
    OP_FRAME    = 2'd2,
    OP_TIMEOUT  = 2'd3
  } opcode_t;

  // Result actions
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_DATA    = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_DONE    = 3'd3,
    ACT_SFAIL   = 3'd4,
    ACT_DELIVER = 3'd5,
    ACT_RFAIL   = 3'd6
  } action_t;

  localparam logic [7:0] TRIES_RESET = 8'd3;

  // One input event
  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] request_len;
    logic [7:0] frame_seq;
    logic       frame_is_ack;
    logic [7:0] frame_len;
  } evt_t;

  // One result item
  typedef struct packed {
    action_t    action;
    logic [7:0] out_seq;
    logic [7:0] out_len;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/swle_ctrl.sv
`default_nettype none

module swle_ctrl
  import swle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire evt_t       evt,
  input  wire logic [7:0] max_tries,
  output result_t         res
);

  mode_t      mode, mode_next;
  logic [7:0] next_seq, next_seq_next;
  logic [7:0] last_rx_seq, last_rx_seq_next;
  logic [7:0] pending_seq, pending_seq_next;
  logic [7:0] pending_len, pending_len_next;
  logic [7:0] rx_capacity, rx_capacity_next;
  logic [7:0] wait_count, wait_count_next;
  logic [7:0] attempt_count, attempt_count_next;
  logic       dup_seen, dup_seen_next;

  logic [7:0] lim;
  logic [7:0] wait_inc;
  logic [7:0] attempt_inc;
  logic       is_frame;
  logic       is_tmo;
  logic       ack_match;

  // State register, updated once per processed event
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      next_seq      <= '0;
      last_rx_seq   <= '0;
      pending_seq   <= '0;
      pending_len   <= '0;
      rx_capacity   <= '0;
      wait_count    <= '0;
      attempt_count <= '0;
      dup_seen      <= 1'b0;
    end else if (fire) begin
      mode          <= mode_next;
      next_seq      <= next_seq_next;
      last_rx_seq   <= last_rx_seq_next;
      pending_seq   <= pending_seq_next;
      pending_len   <= pending_len_next;
      rx_capacity   <= rx_capacity_next;
      wait_count    <= wait_count_next;
      attempt_count <= attempt_count_next;
      dup_seen      <= dup_seen_next;
    end
  end

  // Zero retry limit behaves as one
  assign lim         = (max_tries == 8'd0) ? 8'd1 : max_tries;
  assign wait_inc    = wait_count + 8'd1;
  assign attempt_inc = attempt_count + 8'd1;
  assign is_frame    = (evt.opcode == OP_FRAME);
  assign is_tmo      = (evt.opcode == OP_TIMEOUT);
  assign ack_match   = is_frame && evt.frame_is_ack && (evt.frame_seq == pending_seq);

  // Next state and result for the current event
  always_comb begin
    mode_next          = mode;
    next_seq_next      = next_seq;
    last_rx_seq_next   = last_rx_seq;
    pending_seq_next   = pending_seq;
    pending_len_next   = pending_len;
    rx_capacity_next   = rx_capacity;
    wait_count_next    = wait_count;
    attempt_count_next = attempt_count;
    dup_seen_next      = dup_seen;
    res.action         = ACT_NONE;
    res.out_seq        = '0;
    res.out_len        = '0;

    unique case (mode)
      MODE_IDLE: begin
        if (evt.opcode == OP_SEND_REQ) begin
          pending_len_next   = evt.request_len;
          attempt_count_next = '0;
          pending_seq_next   = next_seq;
          next_seq_next      = next_seq + 8'd1;
          wait_count_next    = '0;
          mode_next          = MODE_SEND;
          res.action         = ACT_DATA;
          res.out_seq        = next_seq;
          res.out_len        = evt.request_len;
        end else if (evt.opcode == OP_RECV_REQ) begin
          rx_capacity_next = evt.request_len;
          dup_seen_next    = 1'b0;
          mode_next        = MODE_RECV;
        end
      end

      MODE_SEND: begin
        if (ack_match) begin
          mode_next   = MODE_IDLE;
          res.action  = ACT_DONE;
          res.out_seq = pending_seq;
          res.out_len = pending_len;
        end else if (is_frame || is_tmo) begin
          wait_count_next = wait_inc;
          if (wait_inc >= lim) begin
            attempt_count_next = attempt_inc;
            if (attempt_inc >= lim) begin
              mode_next  = MODE_IDLE;
              res.action = ACT_SFAIL;
            end else begin
              // Retry with a fresh sequence number
              pending_seq_next = next_seq;
              next_seq_next    = next_seq + 8'd1;
              wait_count_next  = '0;
              res.action       = ACT_DATA;
              res.out_seq      = next_seq;
              res.out_len      = pending_len;
            end
          end
        end
      end

      MODE_RECV: begin
        if (is_tmo || (is_frame && (evt.frame_len > rx_capacity))) begin
          if (!dup_seen) begin
            mode_next  = MODE_IDLE;
            res.action = ACT_RFAIL;
          end
        end else if (is_frame) begin
          if (evt.frame_seq == last_rx_seq) begin
            // Drop duplicate, keep waiting
            dup_seen_next = 1'b1;
          end else begin
            last_rx_seq_next = evt.frame_seq;
            dup_seen_next    = 1'b0;
            if (evt.frame_is_ack) begin
              mode_next  = MODE_IDLE;
              res.action = ACT_RFAIL;
            end else begin
              pending_seq_next = evt.frame_seq;
              pending_len_next = evt.frame_len;
              wait_count_next  = '0;
              mode_next        = MODE_ECHO;
              res.action       = ACT_ACK;
              res.out_seq      = evt.frame_seq;
            end
          end
        end
      end

      MODE_ECHO: begin
        if (ack_match) begin
          mode_next   = MODE_IDLE;
          res.action  = ACT_DELIVER;
          res.out_len = pending_len;
        end else if (is_frame || is_tmo) begin
          wait_count_next = wait_inc;
          if (wait_inc >= lim) begin
            mode_next  = MODE_IDLE;
            res.action = ACT_RFAIL;
          end
        end
      end

      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/stop_and_wait_link_engine_unit.sv
`default_nettype none

// Channel  Dir  Handshake          Payload
// s_axis   in   s_tvalid/s_tready  tdata: request_len, frame_seq, frame_len
//                                  tuser: opcode, frame_is_ack
// m_axis   out  m_tvalid/m_tready  tdata: out_seq, out_len; tuser: action
// cfg      in   cfg_wr_en          cfg_wr_data: max_tries
//
// Each event yields exactly one result, passing through the input register
// and then the result register. The link state update is a single
// combinational step, so one event per cycle is sustained while the result side is not stalled.
// Reset (rst, synchronous) empties both stages, idles the link and sets
// max_tries to 3. A stalled result holds its register; the input side
// keeps accepting as long as the result register can move.

module stop_and_wait_link_engine_unit
  import swle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // request_len, frame_seq, frame_len
  input  wire logic [2:0]  s_tuser,   // opcode, frame_is_ack
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // out_seq, out_len
  output logic [2:0]       m_tuser,   // action
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  logic [7:0] tries;
  logic       in_valid;
  evt_t       in_evt;
  logic       advance;
  logic       fire;
  result_t    step_res;
  result_t    out_res;

  // Retry limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      tries <= TRIES_RESET;
    end else if (cfg_wr_en) begin
      tries <= cfg_wr_data;
    end
  end

  // Result register moves when empty or taken
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_evt.opcode       <= opcode_t'(s_tuser[1:0]);
      in_evt.frame_is_ack <= s_tuser[2];
      in_evt.request_len  <= s_tdata[7:0];
      in_evt.frame_seq    <= s_tdata[15:8];
      in_evt.frame_len    <= s_tdata[23:16];
    end
  end

  swle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .evt       (in_evt),
    .max_tries (tries),
    .res       (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= step_res;
    end
  end

  assign m_tuser = out_res.action;
  assign m_tdata = {out_res.out_len, out_res.out_seq};

  // Every processed event lands in the result register
  a_fire_result : assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("processed event produced no result");

  // Actions without a frame carry no sequence or length
  a_quiet_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ACT_NONE || m_tuser == ACT_SFAIL || m_tuser == ACT_RFAIL))
      |-> (m_tdata == 16'd0))
    else $error("empty action carries payload");

  // Delivery carries no sequence number, ACK carries no length
  a_deliver_ack : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ACT_DELIVER || m_tuser == ACT_ACK))
      |-> ((m_tuser == ACT_DELIVER) ? (m_tdata[7:0] == 8'd0) : (m_tdata[15:8] == 8'd0)))
    else $error("deliver or ACK result malformed");

  // Never produce a reserved action code
  a_action_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 3'd7))
    else $error("reserved action code");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swle_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int PHASES       = 6;
  localparam int PHASE_EVENTS = 220;

  // Predicts the link engine and holds the results it owes
  class link_scoreboard;
    logic [7:0] tries;
    mode_t      mode;
    logic [7:0] next_seq;
    logic [7:0] last_rx_seq;
    logic [7:0] pend_seq;
    logic [7:0] pend_len;
    logic [7:0] rx_cap;
    logic [7:0] wait_cnt;
    logic [7:0] attempt_cnt;
    logic       dup_seen;
    result_t    exp_q[$];
    int         errors;

    function new();
      tries       = TRIES_RESET;
      mode        = MODE_IDLE;
      next_seq    = 8'd0;
      last_rx_seq = 8'd0;
      pend_seq    = 8'd0;
      pend_len    = 8'd0;
      rx_cap      = 8'd0;
      wait_cnt    = 8'd0;
      attempt_cnt = 8'd0;
      dup_seen    = 1'b0;
      errors      = 0;
    endfunction

    // A retry limit of zero behaves as one
    function logic [7:0] eff_tries();
      return (tries == 8'd0) ? 8'd1 : tries;
    endfunction

    // Open a send attempt under a fresh sequence number
    function result_t begin_attempt();
      result_t r;
      pend_seq = next_seq;
      next_seq = next_seq + 8'd1;
      wait_cnt = 8'd0;
      mode = MODE_SEND;
      r.action = ACT_DATA;
      r.out_seq = pend_seq;
      r.out_len = pend_len;
      return r;
    endfunction

    function result_t advance(evt_t e);
      result_t r;
      logic    frame;
      logic    tmo;
      logic    hit;
      r.action = ACT_NONE;
      r.out_seq = 8'd0;
      r.out_len = 8'd0;
      frame = (e.opcode == OP_FRAME);
      tmo = (e.opcode == OP_TIMEOUT);
      hit = frame && e.frame_is_ack && (e.frame_seq == pend_seq);
      case (mode)
        MODE_IDLE: begin
          if (e.opcode == OP_SEND_REQ) begin
            pend_len = e.request_len;
            attempt_cnt = 8'd0;
            r = begin_attempt();
          end else if (e.opcode == OP_RECV_REQ) begin
            rx_cap = e.request_len;
            dup_seen = 1'b0;
            mode = MODE_RECV;
          end
        end
        MODE_SEND: begin
          if (hit) begin
            mode = MODE_IDLE;
            r.action = ACT_DONE;
            r.out_seq = pend_seq;
            r.out_len = pend_len;
          end else if (frame || tmo) begin
            wait_cnt = wait_cnt + 8'd1;
            if (wait_cnt >= eff_tries()) begin
              attempt_cnt = attempt_cnt + 8'd1;
              if (attempt_cnt >= eff_tries()) begin
                mode = MODE_IDLE;
                r.action = ACT_SFAIL;
              end else begin
                r = begin_attempt();
              end
            end
          end
        end
        MODE_RECV: begin
          if (tmo || (frame && (e.frame_len > rx_cap))) begin
            // a duplicate earlier in this receive keeps the wait alive
            if (!dup_seen) begin
              mode = MODE_IDLE;
              r.action = ACT_RFAIL;
            end
          end else if (frame) begin
            if (e.frame_seq == last_rx_seq) begin
              dup_seen = 1'b1;
            end else begin
              last_rx_seq = e.frame_seq;
              dup_seen = 1'b0;
              if (e.frame_is_ack) begin
                mode = MODE_IDLE;
                r.action = ACT_RFAIL;
              end else begin
                pend_seq = e.frame_seq;
                pend_len = e.frame_len;
                wait_cnt = 8'd0;
                mode = MODE_ECHO;
                r.action = ACT_ACK;
                r.out_seq = e.frame_seq;
              end
            end
          end
        end
        default: begin
          if (hit) begin
            mode = MODE_IDLE;
            r.action = ACT_DELIVER;
            r.out_len = pend_len;
          end else if (frame || tmo) begin
            wait_cnt = wait_cnt + 8'd1;
            if (wait_cnt >= eff_tries()) begin
              mode = MODE_IDLE;
              r.action = ACT_RFAIL;
            end
          end
        end
      endcase
      return r;
    endfunction

    function void note_input(evt_t e);
      exp_q.push_back(advance(e));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one result transfer with the oldest expectation
    task check_result(result_t got);
      result_t want;
      if (exp_q.size() == 0) begin
        report($sformatf("unexpected result, action %0d", got.action));
        return;
      end
      want = exp_q.pop_front();
      if (got.action !== want.action)
        report($sformatf("action got %0d want %0d", got.action, want.action));
      if (got.out_seq !== want.out_seq)
        report($sformatf("out_seq got %0d want %0d", got.out_seq, want.out_seq));
      if (got.out_len !== want.out_len)
        report($sformatf("out_len got %0d want %0d", got.out_len, want.out_len));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // request_len, frame_seq, frame_len
  logic [2:0]  s_tuser;   // opcode, frame_is_ack
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // out_seq, out_len
  logic [2:0]  m_tuser;   // action
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  link_scoreboard sb;
  int src_idle_pct;
  int sink_idle_pct;
  int stall_cnt;

  stop_and_wait_link_engine_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Record every transfer on both sides
  always @(posedge clk) begin : monitor
    evt_t    e;
    result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.action = action_t'(m_tuser);
        got.out_seq = m_tdata[7:0];
        got.out_len = m_tdata[15:8];
        sb.check_result(got);
      end
      if (s_tvalid && s_tready) begin
        e.opcode = opcode_t'(s_tuser[1:0]);
        e.frame_is_ack = s_tuser[2];
        e.request_len = s_tdata[7:0];
        e.frame_seq = s_tdata[15:8];
        e.frame_len = s_tdata[23:16];
        sb.note_input(e);
      end
    end
  end

  // End the run when transfers stop for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function evt_t mk(opcode_t op, logic [7:0] rlen, logic [7:0] seq, logic ack,
                    logic [7:0] flen);
    evt_t e;
    e.opcode = op;
    e.request_len = rlen;
    e.frame_seq = seq;
    e.frame_is_ack = ack;
    e.frame_len = flen;
    return e;
  endfunction

  // Lean toward the ends of the byte range
  function logic [7:0] pick8();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed traffic for the current link mode, some noise
  function evt_t gen_event();
    evt_t e;
    int   r;
    e = mk(opcode_t'($urandom_range(0, 3)), pick8(), pick8(), 1'($urandom_range(0, 1)),
           pick8());
    r = $urandom_range(0, 99);
    case (sb.mode)
      MODE_IDLE: begin
        if (r < 45) e.opcode = OP_SEND_REQ;
        else if (r < 90) e.opcode = OP_RECV_REQ;
        else e.opcode = ($urandom_range(0, 1) != 0) ? OP_FRAME : OP_TIMEOUT;
      end
      MODE_RECV: begin
        if (r < 55) begin
          e.opcode = OP_FRAME;
          e.frame_is_ack = 1'b0;
          e.frame_seq = 8'(sb.last_rx_seq + 1 + $urandom_range(0, 254));
          e.frame_len = 8'($urandom_range(0, sb.rx_cap));
        end else if (r < 65) begin
          e.opcode = OP_FRAME;
          e.frame_seq = sb.last_rx_seq;
        end else if (r < 73) begin
          e.opcode = OP_FRAME;
          if (sb.rx_cap != 8'hFF) e.frame_len = 8'($urandom_range(sb.rx_cap + 1, 255));
        end else if (r < 81) begin
          e.opcode = OP_FRAME;
          e.frame_is_ack = 1'b1;
          e.frame_seq = 8'(sb.last_rx_seq + 1 + $urandom_range(0, 254));
        end else if (r < 90) begin
          e.opcode = OP_TIMEOUT;
        end
      end
      default: begin
        // send or echo wait: the matching ACK, or events that use up a try
        if (r < 45) begin
          e.opcode = OP_FRAME;
          e.frame_is_ack = 1'b1;
          e.frame_seq = sb.pend_seq;
        end else if (r < 75) begin
          e.opcode = OP_TIMEOUT;
        end else if (r < 90) begin
          e.opcode = OP_FRAME;
        end
      end
    endcase
    return e;
  endfunction

  // Present one event and hold it until its transfer
  task drive_event(evt_t e);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {e.frame_len, e.frame_seq, e.request_len};
    s_tuser = {e.frame_is_ack, e.opcode};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task drain_results();
    while (sb.exp_q.size() != 0) @(negedge clk);
  endtask

  // Write the retry limit once the link has gone quiet
  task write_tries(logic [7:0] v);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_wr_data = v;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.tries = v;
  endtask

  function logic [7:0] tries_for(int p);
    case (p)
      0: return 8'd1;
      1: return 8'd255;
      2: return 8'd0;
      3: return 8'd2;
      4: return 8'd255;
      default: return 8'd7;
    endcase
  endfunction

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    stall_cnt = 0;
    src_idle_pct = 28;
    sink_idle_pct = 68;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed pass under the reset retry limit of three
    drive_event(mk(OP_FRAME, 8'h00, 8'h00, 1'b1, 8'h00));    // ignored while idle
    drive_event(mk(OP_TIMEOUT, 8'hFF, 8'hFF, 1'b0, 8'hFF));  // ignored while idle
    drive_event(mk(OP_SEND_REQ, 8'hFF, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_RECV_REQ, 8'h10, 8'h00, 1'b0, 8'h00)); // ignored while busy
    drive_event(mk(OP_FRAME, 8'h00, 8'h00, 1'b1, 8'h00));
    drive_event(mk(OP_SEND_REQ, 8'h00, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_TIMEOUT, 8'h00, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_FRAME, 8'h00, 8'h01, 1'b0, 8'h00));
    drive_event(mk(OP_FRAME, 8'h00, 8'hFF, 1'b1, 8'h00));    // exhausts, retries
    drive_event(mk(OP_FRAME, 8'h00, 8'h02, 1'b1, 8'h00));
    drive_event(mk(OP_RECV_REQ, 8'hFF, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_FRAME, 8'h00, 8'h00, 1'b0, 8'h05));    // duplicate
    drive_event(mk(OP_TIMEOUT, 8'h00, 8'h00, 1'b0, 8'h00));  // survives duplicate
    drive_event(mk(OP_FRAME, 8'h00, 8'hAA, 1'b0, 8'hFF));
    drive_event(mk(OP_FRAME, 8'h00, 8'hAA, 1'b1, 8'h00));
    drive_event(mk(OP_RECV_REQ, 8'h00, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_FRAME, 8'h00, 8'h01, 1'b0, 8'h01));    // oversize
    drive_event(mk(OP_RECV_REQ, 8'h0A, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_FRAME, 8'h00, 8'h05, 1'b1, 8'h00));    // stray ACK
    drive_event(mk(OP_RECV_REQ, 8'h0A, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_TIMEOUT, 8'h00, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_RECV_REQ, 8'h0A, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_FRAME, 8'h00, 8'h07, 1'b0, 8'h0A));
    drive_event(mk(OP_TIMEOUT, 8'h00, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_SEND_REQ, 8'h33, 8'h00, 1'b0, 8'h00)); // ignored while busy
    drive_event(mk(OP_TIMEOUT, 8'h00, 8'h00, 1'b0, 8'h00));
    drive_event(mk(OP_TIMEOUT, 8'h00, 8'h00, 1'b0, 8'h00));  // echo wait expires

    // Random phases, each under the retry limit and idling mix set for it
    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        src_idle_pct = 28;
        sink_idle_pct = 68;
      end else if (p < 4) begin
        src_idle_pct = 68;
        sink_idle_pct = 28;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      write_tries(tries_for(p));
      for (int i = 0; i < PHASE_EVENTS; i++) begin
        // hold the sender until the result side has caught up
        if (i == PHASE_EVENTS / 2) drain_results();
        drive_event(gen_event());
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (sb.exp_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.exp_q.size()));
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### stop_and_wait_link_engine_unit.f
rtl/core/swle_pkg.sv
rtl/core/swle_ctrl.sv
rtl/core/stop_and_wait_link_engine_unit.sv
tb/sv/testbench.sv
